// ===== rtl/core/iwld_pkg.sv =====
package iwld_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SENSITIVITY   = 3'd0;
	localparam logic [2:0] REG_IDLE_RED      = 3'd1;
	localparam logic [2:0] REG_IDLE_GREEN    = 3'd2;
	localparam logic [2:0] REG_INVERSE_MASS  = 3'd3;
	localparam logic [2:0] REG_FRICTION      = 3'd4;
	localparam logic [2:0] REG_DEADBAND      = 3'd5;

	// register reset values
	localparam logic [7:0]  SENSITIVITY_RST   = 8'd5;
	localparam logic [7:0]  IDLE_RED_RST      = 8'd60;
	localparam logic [7:0]  IDLE_GREEN_RST    = 8'd45;
	localparam logic [15:0] INVERSE_MASS_RST  = 16'd1092;
	localparam logic [15:0] FRICTION_RST      = 16'd65208;
	localparam logic [15:0] DEADBAND_RST      = 16'd66;

	// action codes
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	localparam logic [7:0] LEVEL_MAX = 8'd255;

	typedef struct packed {
		logic        action;
		logic [15:0] enc_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] dot_index;
		logic [5:0] dot_level;
		logic [7:0] next_index;
		logic [5:0] next_level;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  sensitivity;
		logic [7:0]  idle_red;
		logic [7:0]  idle_green;
		logic [15:0] inverse_mass;
		logic [15:0] friction;
		logic [15:0] deadband;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul;
		logic sat;
		logic fric;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_action;
		logic out_stall;
	} stat_t;

	// clamp a color level to 0..255
	function automatic logic [7:0] clamp_level(input logic signed [25:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 26'sd255) begin
			r = LEVEL_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/iwld_in_if.sv =====
interface iwld_in_if import iwld_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/iwld_out_if.sv =====
interface iwld_out_if import iwld_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/iwld_regs.sv =====
module iwld_regs import iwld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensitivity  <= SENSITIVITY_RST;
			cfg_q.idle_red     <= IDLE_RED_RST;
			cfg_q.idle_green   <= IDLE_GREEN_RST;
			cfg_q.inverse_mass <= INVERSE_MASS_RST;
			cfg_q.friction     <= FRICTION_RST;
			cfg_q.deadband     <= DEADBAND_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SENSITIVITY:  cfg_q.sensitivity  <= pwdata[7:0];
				REG_IDLE_RED:     cfg_q.idle_red     <= pwdata[7:0];
				REG_IDLE_GREEN:   cfg_q.idle_green   <= pwdata[7:0];
				REG_INVERSE_MASS: cfg_q.inverse_mass <= pwdata[15:0];
				REG_FRICTION:     cfg_q.friction     <= pwdata[15:0];
				REG_DEADBAND:     cfg_q.deadband     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_SENSITIVITY:  prdata = {24'd0, cfg_q.sensitivity};
			REG_IDLE_RED:     prdata = {24'd0, cfg_q.idle_red};
			REG_IDLE_GREEN:   prdata = {24'd0, cfg_q.idle_green};
			REG_INVERSE_MASS: prdata = {16'd0, cfg_q.inverse_mass};
			REG_FRICTION:     prdata = {16'd0, cfg_q.friction};
			REG_DEADBAND:     prdata = {16'd0, cfg_q.deadband};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/iwld_ctrl.sv =====
module iwld_ctrl import iwld_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SAT  = 3'd2;
	localparam logic [2:0] S_FRIC = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       finish;
	logic       accept;

	// a new item may enter while the previous one finishes
	assign finish   = (state_q == S_FIN) && !stat.out_stall;
	assign in_ready = (state_q == S_IDLE) || finish;
	assign accept   = in_ready && stat.in_valid;

	assign cmd.accept = accept;
	assign cmd.mul    = (state_q == S_MUL);
	assign cmd.sat    = (state_q == S_SAT);
	assign cmd.fric   = (state_q == S_FRIC);
	assign cmd.fin    = finish;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (stat.in_action == ACT_UPDATE) ? S_MUL : S_FIN;
				end
			end
			S_MUL:  state_d = S_SAT;
			S_SAT:  state_d = S_FRIC;
			S_FRIC: state_d = S_FIN;
			S_FIN: begin
				if (accept) begin
					state_d = (stat.in_action == ACT_UPDATE) ? S_MUL : S_FIN;
				end else if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/iwld_dp.sv =====
module iwld_dp import iwld_pkg::*; #(
	parameter int LED_COUNT = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  in_item_t  in_data,
	input  logic      in_valid,
	input  logic      out_ready,
	output stat_t     stat,
	output logic      out_valid,
	output out_item_t out_data
);

	// ring length in q8.16 and velocity limit
	localparam logic signed [25:0] RING   = 26'(LED_COUNT * 65536);
	localparam logic signed [33:0] VLIMIT = 34'(LED_COUNT * 65536 - 1);
	localparam logic [8:0]         LEDS   = 9'(LED_COUNT);

	// motion state
	logic [15:0]        prev_q;
	logic signed [24:0] vel_q;
	logic [23:0]        pos_q;

	// per-item stages
	logic               action_s1;
	logic signed [15:0] delta_s1;
	logic [23:0]        change_s2;
	logic signed [32:0] dprod_s2;
	logic [23:0]        mag_s3;
	logic               neg_s3;
	logic [7:0]         red_s3;
	logic [7:0]         green_s3;

	logic               out_valid_q;
	out_item_t          out_q;

	// combinational
	logic [15:0]        mag_d;
	logic signed [33:0] vsum;
	logic signed [33:0] vclamp;
	logic [23:0]        vmag;
	logic signed [25:0] red_w;
	logic signed [25:0] green_w;
	logic [39:0]        fprod;
	logic [23:0]        fmag;
	logic signed [25:0] psum;
	logic [23:0]        pos_new;
	logic [8:0]         idx_inc;
	logic [16:0]        frac_inv;

	assign stat.in_valid  = in_valid;
	assign stat.in_action = in_data.action;
	assign stat.out_stall = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	// magnitude of the count delta
	assign mag_d = delta_s1[15] ? 16'(-delta_s1) : 16'(delta_s1);

	// velocity plus impulse, saturated
	always_comb begin
		vsum = 34'(vel_q) + 34'(dprod_s2);
		if (vsum > VLIMIT) begin
			vclamp = VLIMIT;
		end else if (vsum < -VLIMIT) begin
			vclamp = -VLIMIT;
		end else begin
			vclamp = vsum;
		end
		vmag = vclamp[33] ? 24'(-vclamp) : 24'(vclamp);
	end

	// color shift toward green or red
	always_comb begin
		red_w   = 26'(cfg.idle_red);
		green_w = 26'(cfg.idle_green);
		if (delta_s1 > 0) begin
			red_w   = 26'(cfg.idle_red) - 26'(change_s2);
			green_w = 26'(cfg.idle_green) + 26'(change_s2);
		end else if (delta_s1 < 0) begin
			red_w   = 26'(cfg.idle_red) + 26'(change_s2);
			green_w = 26'(cfg.idle_green) - 26'(change_s2);
		end
	end

	// friction and deadband
	always_comb begin
		fprod = 40'(mag_s3) * 40'(cfg.friction);
		fmag  = fprod[39:16];
		if (fmag < 24'(cfg.deadband)) begin
			fmag = 24'd0;
		end
	end

	// position step with single wrap, and the dot pixels
	always_comb begin
		psum = 26'(pos_q) + 26'(vel_q);
		if (psum >= RING) begin
			psum = psum - RING;
		end
		if (psum < 0) begin
			psum = psum + RING;
		end
		pos_new  = (action_s1 == ACT_UPDATE) ? psum[23:0] : 24'd0;
		idx_inc  = 9'(pos_new[23:16]) + 9'd1;
		frac_inv = 17'h10000 - 17'(pos_new[15:0]);
	end

	// item stages
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_s1 <= in_data.action;
			delta_s1  <= in_data.enc_count - prev_q;
		end
		if (cmd.mul) begin
			change_s2 <= 24'(mag_d) * 24'(cfg.sensitivity);
			dprod_s2  <= 33'(delta_s1) * 33'({1'b0, cfg.inverse_mass});
		end
		if (cmd.sat) begin
			mag_s3   <= vmag;
			neg_s3   <= vclamp[33];
			red_s3   <= clamp_level(red_w);
			green_s3 <= clamp_level(green_w);
		end
		if (cmd.fin) begin
			out_q.red        <= (action_s1 == ACT_UPDATE) ? red_s3 : cfg.idle_red;
			out_q.green      <= (action_s1 == ACT_UPDATE) ? green_s3 : cfg.idle_green;
			out_q.dot_index  <= pos_new[23:16];
			out_q.dot_level  <= frac_inv[16:11];
			out_q.next_index <= (idx_inc == LEDS) ? 8'd0 : idx_inc[7:0];
			out_q.next_level <= {1'b0, pos_new[15:11]};
		end
	end

	// motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 16'd0;
			vel_q  <= 25'sd0;
			pos_q  <= 24'd0;
		end else begin
			if (cmd.accept) begin
				prev_q <= in_data.enc_count;
			end
			if (cmd.fric) begin
				vel_q <= neg_s3 ? -25'(fmag) : 25'(fmag);
			end else if (cmd.fin && action_s1 == ACT_START) begin
				vel_q <= 25'sd0;
			end
			if (cmd.fin) begin
				pos_q <= pos_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/inertia_wheel_led_dot_top.sv =====
// channel   dir  handshake        payload
// item      in   valid / ready    action, enc_count
// result    out  valid / ready    red, green, dot_index, dot_level, next_index, next_level
// apb       in   psel / penable   paddr, pwdata, prdata (6 registers at 4-byte steps)
//
// an update item goes from acceptance to result through multiply, saturate,
// friction multiply and position step; a start item goes straight to the position step
// a new item is accepted in the cycle its predecessor's result is registered,
// so updates overlap only there and otherwise run one at a time through the shared state sequence
// reset clears the motion state and restores register defaults
// a result waiting in the output register stalls the sequencer at its last step
module inertia_wheel_led_dot_top import iwld_pkg::*; #(
	parameter int LED_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	iwld_in_if.sink     item,
	iwld_out_if.source  result
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	iwld_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iwld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.in_ready (item.ready),
		.cmd      (cmd)
	);

	iwld_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.in_data   (item.data),
		.in_valid  (item.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.out_valid (result.valid),
		.out_data  (result.data)
	);

endmodule
